[hdl/pinhole_camera_ray_direction_core_defines.svh]
// ----------------------------------------------------------------------------
// Pinhole camera ray direction: assertion macros
// Shared concurrent check forms, clocked on i_clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef PINHOLE_CAMERA_RAY_DIRECTION_CORE_DEFINES_SVH
`define PINHOLE_CAMERA_RAY_DIRECTION_CORE_DEFINES_SVH

// Same-cycle implication check
`define PCRD_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("pcrd check failed");

// Next-cycle implication check
`define PCRD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pcrd check failed");

`endif

[hdl/pcrd_pkg.sv]
// ----------------------------------------------------------------------------
// Pinhole camera ray direction: package
// Shared constants, register indexes, types and the Q1.14 rounding helper.
// ----------------------------------------------------------------------------
package pcrd_pkg;

    localparam int COORD_BITS_DEF    = 12;
    localparam int DIR_FRAC_BITS_DEF = 15;
    // Width of the unnormalized direction vector at the default coordinate width
    localparam int VW_DEF            = 52;
    // Magnitudes are scaled below 2^NORM_BITS before squaring
    localparam int NORM_BITS         = 30;
    localparam int CFG_DW            = 16;
    localparam int CFG_IW            = 3;

    typedef enum logic [CFG_IW-1:0] {
        REG_SIN_PITCH   = 3'd0,
        REG_COS_PITCH   = 3'd1,
        REG_SIN_YAW     = 3'd2,
        REG_COS_YAW     = 3'd3,
        REG_FOV_SCALE   = 3'd4,
        REG_VIEW_WIDTH  = 3'd5,
        REG_VIEW_HEIGHT = 3'd6
    } t_reg_idx;

    localparam logic [15:0] RST_SIN_PITCH   = 16'd0;
    localparam logic [15:0] RST_COS_PITCH   = 16'd16384;
    localparam logic [15:0] RST_SIN_YAW     = 16'd0;
    localparam logic [15:0] RST_COS_YAW     = 16'd16384;
    localparam logic [15:0] RST_FOV_SCALE   = 16'd9459;
    localparam logic [12:0] RST_VIEW_WIDTH  = 13'd640;
    localparam logic [12:0] RST_VIEW_HEIGHT = 13'd480;

    // Valid flag and component signs that travel with a request
    typedef struct packed {
        logic       valid;
        logic [2:0] neg;
    } t_tag;

    // Round a Q2.28 product to Q1.14, ties toward plus infinity
    function automatic logic signed [17:0] round14(input logic signed [33:0] p);
        logic signed [33:0] t;
        t = p + 34'sd8192;
        return 18'(t >>> 14);
    endfunction

endpackage

[hdl/pinhole_camera_ray_direction_core.sv]
// ----------------------------------------------------------------------------
// Pinhole camera ray direction core
// Unit direction of the primary ray through a pixel centre, from configured
// pitch/yaw trig values, field of view scale and viewport size.
// ----------------------------------------------------------------------------
// Usage:
//   Requests: drive i_pixel_x/i_pixel_y with i_start high; a request is taken
//   at every clock edge where i_start is high and o_busy is low. o_busy stays
//   low, so one request per cycle is sustained.
//   Results: o_valid strobes for one cycle with o_dir_x/y/z (signed
//   Q1.DIR_FRAC_BITS); the receiver cannot stall and results are never held.
//   The pipe has 3 basis/vector stages, 5 scaling stages, 32 square root
//   stages (one root bit each) and DIR_FRAC_BITS + 3 divider stages (one
//   quotient bit each, then output). Results leave in request order.
//   Configuration: write i_cfg_wdata to register i_cfg_idx with i_cfg_we;
//   write only while no request is in flight. Unknown indexes are ignored.
//   Reset (synchronous, active low) restores the register defaults and
//   drops every request in flight.
// ----------------------------------------------------------------------------
`include "pinhole_camera_ray_direction_core_defines.svh"

module pinhole_camera_ray_direction_core #(
    parameter int COORD_BITS    = pcrd_pkg::COORD_BITS_DEF,
    parameter int DIR_FRAC_BITS = pcrd_pkg::DIR_FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    input  logic [COORD_BITS-1:0]         i_pixel_x,
    input  logic [COORD_BITS-1:0]         i_pixel_y,
    input  logic                          i_cfg_we,
    input  logic [pcrd_pkg::CFG_IW-1:0]   i_cfg_idx,
    input  logic [pcrd_pkg::CFG_DW-1:0]   i_cfg_wdata,
    output logic                          o_valid,
    output logic signed [DIR_FRAC_BITS:0] o_dir_x,
    output logic signed [DIR_FRAC_BITS:0] o_dir_y,
    output logic signed [DIR_FRAC_BITS:0] o_dir_z
);
    import pcrd_pkg::*;

    localparam int CB  = (COORD_BITS > 12) ? COORD_BITS : 12;
    localparam int VW  = CB + 40;
    localparam int LAT = 43 + DIR_FRAC_BITS;
    localparam logic [DIR_FRAC_BITS:0] MIN_CODE = {1'b1, {DIR_FRAC_BITS{1'b0}}};

    logic [15:0] r_sin_pitch, r_cos_pitch, r_sin_yaw, r_cos_yaw, r_fov_scale;
    logic [12:0] r_view_width, r_view_height;

    logic                 accept;
    logic                 v_valid;
    logic signed [VW-1:0] v_vec [3];
    t_tag                 nm_tag, sq_tag;
    logic [NORM_BITS-1:0] nm_m [3], sq_m [3];
    logic [63:0]          nm_sum;
    logic [31:0]          sq_root;
    logic [DIR_FRAC_BITS:0] q [3];
    logic                 div_valid_y, div_valid_z;
    logic                 q_no_min;

    assign o_busy = 1'b0;
    assign accept = i_start && !o_busy;

    // Hold configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sin_pitch   <= RST_SIN_PITCH;
            r_cos_pitch   <= RST_COS_PITCH;
            r_sin_yaw     <= RST_SIN_YAW;
            r_cos_yaw     <= RST_COS_YAW;
            r_fov_scale   <= RST_FOV_SCALE;
            r_view_width  <= RST_VIEW_WIDTH;
            r_view_height <= RST_VIEW_HEIGHT;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_SIN_PITCH:   r_sin_pitch   <= i_cfg_wdata;
                REG_COS_PITCH:   r_cos_pitch   <= i_cfg_wdata;
                REG_SIN_YAW:     r_sin_yaw     <= i_cfg_wdata;
                REG_COS_YAW:     r_cos_yaw     <= i_cfg_wdata;
                REG_FOV_SCALE:   r_fov_scale   <= i_cfg_wdata;
                REG_VIEW_WIDTH:  r_view_width  <= i_cfg_wdata[12:0];
                REG_VIEW_HEIGHT: r_view_height <= i_cfg_wdata[12:0];
                default: begin
                end
            endcase
        end
    end

    pcrd_basis #(
        .COORD_BITS (COORD_BITS),
        .VW         (VW)
    ) u_basis (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (accept),
        .i_pixel_x     (i_pixel_x),
        .i_pixel_y     (i_pixel_y),
        .i_sin_pitch   (r_sin_pitch),
        .i_cos_pitch   (r_cos_pitch),
        .i_sin_yaw     (r_sin_yaw),
        .i_cos_yaw     (r_cos_yaw),
        .i_fov_scale   (r_fov_scale),
        .i_view_width  (r_view_width),
        .i_view_height (r_view_height),
        .o_valid       (v_valid),
        .o_v           (v_vec)
    );

    pcrd_norm #(
        .VW (VW)
    ) u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (v_valid),
        .i_v     (v_vec),
        .o_tag   (nm_tag),
        .o_m     (nm_m),
        .o_sum   (nm_sum)
    );

    pcrd_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (nm_tag),
        .i_m     (nm_m),
        .i_rad   (nm_sum),
        .o_tag   (sq_tag),
        .o_m     (sq_m),
        .o_root  (sq_root)
    );

    // Divide each component by the norm
    pcrd_div #(
        .DIR_FRAC_BITS (DIR_FRAC_BITS)
    ) u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (sq_tag.valid),
        .i_m     (sq_m[0]),
        .i_n     (sq_root),
        .i_neg   (sq_tag.neg[0]),
        .o_valid (o_valid),
        .o_q     (q[0])
    );

    pcrd_div #(
        .DIR_FRAC_BITS (DIR_FRAC_BITS)
    ) u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (sq_tag.valid),
        .i_m     (sq_m[1]),
        .i_n     (sq_root),
        .i_neg   (sq_tag.neg[1]),
        .o_valid (div_valid_y),
        .o_q     (q[1])
    );

    pcrd_div #(
        .DIR_FRAC_BITS (DIR_FRAC_BITS)
    ) u_div_z (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (sq_tag.valid),
        .i_m     (sq_m[2]),
        .i_n     (sq_root),
        .i_neg   (sq_tag.neg[2]),
        .o_valid (div_valid_z),
        .o_q     (q[2])
    );

    assign o_dir_x = $signed(q[0]);
    assign o_dir_y = $signed(q[1]);
    assign o_dir_z = $signed(q[2]);

    // Flag results that avoid the most negative code
    assign q_no_min = (q[0] != MIN_CODE) && (q[1] != MIN_CODE) && (q[2] != MIN_CODE);

    // Every result traces back to an accepted request
    `PCRD_ASSERT_IMPLY(a_result_has_request, o_valid, $past(accept, LAT))
    // Saturation is symmetric: the most negative code never appears
    `PCRD_ASSERT_IMPLY(a_no_min_code, o_valid, q_no_min)
    // The three component dividers stay in step
    `PCRD_ASSERT_IMPLY(a_lanes_aligned, 1'b1, (div_valid_y == o_valid) && (div_valid_z == o_valid))

endmodule

[hdl/pcrd_basis.sv]
// ----------------------------------------------------------------------------
// Pinhole camera ray direction: basis and vector stages
// Builds the camera basis and pixel offsets, multiplies, and sums the
// unnormalized direction over three register stages.
// ----------------------------------------------------------------------------
module pcrd_basis #(
    parameter int COORD_BITS = pcrd_pkg::COORD_BITS_DEF,
    parameter int VW         = pcrd_pkg::VW_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic [COORD_BITS-1:0] i_pixel_x,
    input  logic [COORD_BITS-1:0] i_pixel_y,
    input  logic [15:0]           i_sin_pitch,
    input  logic [15:0]           i_cos_pitch,
    input  logic [15:0]           i_sin_yaw,
    input  logic [15:0]           i_cos_yaw,
    input  logic [15:0]           i_fov_scale,
    input  logic [12:0]           i_view_width,
    input  logic [12:0]           i_view_height,
    output logic                  o_valid,
    output logic signed [VW-1:0]  o_v [3]
);
    import pcrd_pkg::*;

    localparam int CB = (COORD_BITS > 12) ? COORD_BITS : 12;
    localparam int XW = CB + 3;
    localparam int AW = XW + 17;

    logic signed [15:0]   sp, cp, sy, cy;
    logic [12:0]          h_eff;
    logic signed [XW-1:0] xo, yo;
    logic signed [17:0]   n_f [3];
    logic signed [16:0]   n_r [3];
    logic signed [17:0]   n_u [3];
    logic signed [AW-1:0] n_a, n_b;
    logic [26:0]          n_d;

    logic                 r_s1_valid, r_s2_valid, r_s3_valid;
    logic signed [17:0]   r_f [3];
    logic signed [16:0]   r_r [3];
    logic signed [17:0]   r_u [3];
    logic signed [AW-1:0] r_a, r_b;
    logic [26:0]          r_d;
    logic signed [VW-1:0] n_pf [3], n_pr [3], n_pu [3];
    logic signed [VW-1:0] r_pf [3], r_pr [3], r_pu [3];
    logic signed [VW-1:0] r_v [3];

    // Form basis vectors and half-pixel offsets
    always_comb begin
        sp    = $signed(i_sin_pitch);
        cp    = $signed(i_cos_pitch);
        sy    = $signed(i_sin_yaw);
        cy    = $signed(i_cos_yaw);
        h_eff = (i_view_height == '0) ? 13'd1 : i_view_height;
        n_f[0] = round14(34'(cp) * 34'(sy));
        n_f[1] = round14(34'(cp) * 34'(cy));
        n_f[2] = 18'(sp);
        n_r[0] = 17'(cy);
        n_r[1] = -17'(sy);
        n_r[2] = '0;
        n_u[0] = round14(-(34'(sy) * 34'(sp)));
        n_u[1] = round14(-(34'(cy) * 34'(sp)));
        n_u[2] = 18'(cp);
        xo  = $signed(XW'({i_pixel_x, 1'b0})) - $signed(XW'(i_view_width))
              + $signed(XW'(1));
        yo  = $signed(XW'({i_pixel_y, 1'b0})) - $signed(XW'(h_eff))
              + $signed(XW'(1));
        n_a = AW'(xo) * $signed({1'b0, i_fov_scale});
        n_b = AW'(yo) * $signed({1'b0, i_fov_scale});
        n_d = 27'(h_eff) << 14;
    end

    // Multiply basis terms by the scaled offsets
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_pf[i] = VW'(r_f[i]) * VW'($signed({1'b0, r_d}));
            n_pr[i] = VW'(r_r[i]) * VW'(r_a);
            n_pu[i] = VW'(r_u[i]) * VW'(r_b);
        end
    end

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_valid;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
        end
    end

    // Advance payload
    always_ff @(posedge i_clk) begin
        r_f <= n_f;
        r_r <= n_r;
        r_u <= n_u;
        r_a <= n_a;
        r_b <= n_b;
        r_d <= n_d;
        r_pf <= n_pf;
        r_pr <= n_pr;
        r_pu <= n_pu;
        for (int i = 0; i < 3; i++) begin
            r_v[i] <= r_pf[i] + r_pr[i] - r_pu[i];
        end
    end

    assign o_valid = r_s3_valid;
    assign o_v     = r_v;

endmodule

[hdl/pcrd_norm.sv]
// ----------------------------------------------------------------------------
// Pinhole camera ray direction: magnitude scaling
// Takes magnitudes, scales them below 2^30 and sums their squares over
// five register stages.
// ----------------------------------------------------------------------------
module pcrd_norm #(
    parameter int VW = pcrd_pkg::VW_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  logic signed [VW-1:0]            i_v [3],
    output pcrd_pkg::t_tag                  o_tag,
    output logic [pcrd_pkg::NORM_BITS-1:0]  o_m [3],
    output logic [63:0]                     o_sum
);
    import pcrd_pkg::*;

    localparam int SW = $clog2(VW);

    logic [VW-1:0]        n_mag [3];
    logic [VW-1:0]        n_big;
    logic [SW-1:0]        n_sh;
    logic [NORM_BITS-1:0] n_ms [3];

    t_tag                 r4_tag, r5_tag, r6_tag, r7_tag, r8_tag;
    logic [VW-1:0]        r4_m [3], r5_m [3];
    logic [VW-1:0]        r4_big;
    logic [SW-1:0]        r5_sh;
    logic [NORM_BITS-1:0] r6_m [3], r7_m [3], r8_m [3];
    logic [2*NORM_BITS-1:0] r7_sq [3];
    logic [63:0]          r8_sum;

    // Take magnitudes and the largest of them
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_mag[i] = i_v[i][VW-1] ? VW'(-i_v[i]) : VW'(i_v[i]);
        end
        n_big = n_mag[0];
        if (n_mag[1] > n_big) begin
            n_big = n_mag[1];
        end
        if (n_mag[2] > n_big) begin
            n_big = n_mag[2];
        end
    end

    // Find the shift that brings the largest magnitude below 2^NORM_BITS, and shift the magnitudes
    always_comb begin
        n_sh = '0;
        for (int k = NORM_BITS; k < VW; k++) begin
            if (r4_big[k]) begin
                n_sh = SW'(k - NORM_BITS + 1);
            end
        end
        for (int i = 0; i < 3; i++) begin
            n_ms[i] = NORM_BITS'(r5_m[i] >> r5_sh);
        end
    end

    // Advance tags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_tag <= '0;
            r5_tag <= '0;
            r6_tag <= '0;
            r7_tag <= '0;
            r8_tag <= '0;
        end else begin
            r4_tag.valid <= i_valid;
            for (int i = 0; i < 3; i++) begin
                r4_tag.neg[i] <= i_v[i][VW-1];
            end
            r5_tag <= r4_tag;
            r6_tag <= r5_tag;
            r7_tag <= r6_tag;
            r8_tag <= r7_tag;
        end
    end

    // Advance payload
    always_ff @(posedge i_clk) begin
        r4_m   <= n_mag;
        r4_big <= n_big;
        r5_m   <= r4_m;
        r5_sh  <= n_sh;
        r6_m   <= n_ms;
        r7_m   <= r6_m;
        for (int i = 0; i < 3; i++) begin
            r7_sq[i] <= r6_m[i] * r6_m[i];
        end
        r8_m   <= r7_m;
        r8_sum <= 64'(r7_sq[0]) + 64'(r7_sq[1]) + 64'(r7_sq[2]);
    end

    assign o_tag = r8_tag;
    assign o_m   = r8_m;
    assign o_sum = r8_sum;

endmodule

[hdl/pcrd_isqrt.sv]
// ----------------------------------------------------------------------------
// Pinhole camera ray direction: square root pipeline
// Integer square root of a 64-bit sum, one root bit per register stage.
// ----------------------------------------------------------------------------
module pcrd_isqrt (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  pcrd_pkg::t_tag                  i_tag,
    input  logic [pcrd_pkg::NORM_BITS-1:0]  i_m [3],
    input  logic [63:0]                     i_rad,
    output pcrd_pkg::t_tag                  o_tag,
    output logic [pcrd_pkg::NORM_BITS-1:0]  o_m [3],
    output logic [31:0]                     o_root
);
    import pcrd_pkg::*;

    localparam int STEPS = 32;

    t_tag                 c_tag  [STEPS];
    logic [NORM_BITS-1:0] c_m    [STEPS][3];
    logic [35:0]          c_rem  [STEPS];
    logic [63:0]          c_rad  [STEPS];
    logic [31:0]          c_root [STEPS];
    logic [35:0]          n_rem  [STEPS];
    logic [31:0]          n_root [STEPS];

    t_tag                 r_tag  [STEPS];
    logic [NORM_BITS-1:0] r_m    [STEPS][3];
    logic [35:0]          r_rem  [STEPS];
    logic [63:0]          r_rad  [STEPS];
    logic [31:0]          r_root [STEPS];

    // Select each stage's operands and try the next root bit
    always_comb begin
        logic [35:0] rem2;
        logic [35:0] trial;
        c_tag[0]  = i_tag;
        c_m[0]    = i_m;
        c_rem[0]  = '0;
        c_rad[0]  = i_rad;
        c_root[0] = '0;
        for (int k = 1; k < STEPS; k++) begin
            c_tag[k]  = r_tag[k-1];
            c_m[k]    = r_m[k-1];
            c_rem[k]  = r_rem[k-1];
            c_rad[k]  = r_rad[k-1];
            c_root[k] = r_root[k-1];
        end
        for (int k = 0; k < STEPS; k++) begin
            rem2  = {c_rem[k][33:0], c_rad[k][63:62]};
            trial = {2'b00, c_root[k], 2'b01};
            if (rem2 >= trial) begin
                n_rem[k]  = rem2 - trial;
                n_root[k] = {c_root[k][30:0], 1'b1};
            end else begin
                n_rem[k]  = rem2;
                n_root[k] = {c_root[k][30:0], 1'b0};
            end
        end
    end

    // Advance tags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < STEPS; k++) begin
                r_tag[k] <= '0;
            end
        end else begin
            r_tag <= c_tag;
        end
    end

    // Advance payload
    always_ff @(posedge i_clk) begin
        r_m    <= c_m;
        r_rem  <= n_rem;
        r_root <= n_root;
        for (int k = 0; k < STEPS; k++) begin
            r_rad[k] <= {c_rad[k][61:0], 2'b00};
        end
    end

    assign o_tag  = r_tag[STEPS-1];
    assign o_m    = r_m[STEPS-1];
    assign o_root = r_root[STEPS-1];

endmodule

[hdl/pcrd_div.sv]
// ----------------------------------------------------------------------------
// Pinhole camera ray direction: component divider
// Rounded quotient of one scaled magnitude by the norm, one quotient bit per
// register stage, then saturation and sign.
// ----------------------------------------------------------------------------
module pcrd_div #(
    parameter int DIR_FRAC_BITS = pcrd_pkg::DIR_FRAC_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  logic [pcrd_pkg::NORM_BITS-1:0]  i_m,
    input  logic [31:0]                     i_n,
    input  logic                            i_neg,
    output logic                            o_valid,
    output logic signed [DIR_FRAC_BITS:0]   o_q
);
    import pcrd_pkg::*;

    localparam int F  = DIR_FRAC_BITS;
    localparam int QW = F + 2;
    localparam int NW = NORM_BITS + F + 1;
    localparam logic [QW-1:0] OUT_MAX = QW'((64'd1 << F) - 64'd1);

    logic [NW-1:0] num;
    logic          c_valid [QW];
    logic          c_neg   [QW];
    logic [31:0]   c_n     [QW];
    logic [31:0]   c_rem   [QW];
    logic [QW-1:0] c_lq    [QW];
    logic [31:0]   n_rem   [QW];
    logic [QW-1:0] n_lq    [QW];
    logic [QW-1:0] q_sat;
    logic [F:0]    n_q;

    logic          r_valid [QW];
    logic          r_neg   [QW];
    logic [31:0]   r_n     [QW];
    logic [31:0]   r_rem   [QW];
    logic [QW-1:0] r_lq    [QW];
    logic          r_out_valid;
    logic [F:0]    r_q;

    // Shift in numerator bits and subtract the norm where it fits
    always_comb begin
        logic [32:0] rem2;
        logic        ge;
        num        = (NW'(i_m) << F) + NW'(i_n >> 1);
        c_valid[0] = i_valid;
        c_neg[0]   = i_neg;
        c_n[0]     = i_n;
        c_rem[0]   = 32'(num[NW-1:QW]);
        c_lq[0]    = num[QW-1:0];
        for (int k = 1; k < QW; k++) begin
            c_valid[k] = r_valid[k-1];
            c_neg[k]   = r_neg[k-1];
            c_n[k]     = r_n[k-1];
            c_rem[k]   = r_rem[k-1];
            c_lq[k]    = r_lq[k-1];
        end
        for (int k = 0; k < QW; k++) begin
            rem2     = {c_rem[k], c_lq[k][QW-1]};
            ge       = rem2 >= {1'b0, c_n[k]};
            n_rem[k] = ge ? 32'(rem2 - {1'b0, c_n[k]}) : rem2[31:0];
            n_lq[k]  = {c_lq[k][QW-2:0], ge};
        end
    end

    // Clamp, drop a zero norm and restore the sign
    always_comb begin
        q_sat = (r_lq[QW-1] > OUT_MAX) ? OUT_MAX : r_lq[QW-1];
        if (r_n[QW-1] == '0) begin
            q_sat = '0;
        end
        n_q = r_neg[QW-1] ? (F+1)'(-q_sat) : (F+1)'(q_sat);
    end

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < QW; k++) begin
                r_valid[k] <= 1'b0;
            end
            r_out_valid <= 1'b0;
        end else begin
            r_valid     <= c_valid;
            r_out_valid <= r_valid[QW-1];
        end
    end

    // Advance payload
    always_ff @(posedge i_clk) begin
        r_neg <= c_neg;
        r_n   <= c_n;
        r_rem <= n_rem;
        r_lq  <= n_lq;
        r_q   <= n_q;
    end

    assign o_valid = r_out_valid;
    assign o_q     = $signed(r_q);

endmodule

[tb/sv/tb_top.sv]
// ----------------------------------------------------------------------------
// Pinhole camera ray direction: testbench
// Drives pixel requests in bursts against a bit-exact direction predictor,
// runs through several camera settings and checks each direction component.
// ----------------------------------------------------------------------------
module tb_top;

    import pcrd_pkg::*;

    localparam int  DRAIN_CYCLES = 70;
    localparam int  CYCLE_LIMIT  = 400000;
    localparam logic [CFG_IW-1:0] REG_UNKNOWN = 3'd7;

    typedef enum logic {ROW_CFG, ROW_PIX} t_row_kind;

    typedef struct {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } t_dir;

    typedef struct {
        t_row_kind          kind;
        logic [CFG_IW-1:0]  idx;
        logic [15:0]        data;
        logic [11:0]        px;
        logic [11:0]        py;
        logic               typed;
        t_dir               dir;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_start;
    logic        o_busy;
    logic [11:0] i_pixel_x;
    logic [11:0] i_pixel_y;
    logic        i_cfg_we;
    logic [CFG_IW-1:0] i_cfg_idx;
    logic [CFG_DW-1:0] i_cfg_wdata;
    logic        o_valid;
    logic signed [15:0] o_dir_x;
    logic signed [15:0] o_dir_y;
    logic signed [15:0] o_dir_z;

    // Camera settings as the block holds them
    logic [15:0] cam_sp, cam_cp, cam_sy, cam_cy, cam_fov;
    logic [12:0] cam_w, cam_h;

    t_dir pending_dirs[$];
    int   fail_count = 0;
    int   cycle_count = 0;

    pinhole_camera_ray_direction_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_pixel_x   (i_pixel_x),
        .i_pixel_y   (i_pixel_y),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_valid     (o_valid),
        .o_dir_x     (o_dir_x),
        .o_dir_y     (o_dir_y),
        .o_dir_z     (o_dir_z)
    );

    // Clock
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    // Q2.28 product to Q1.14, ties toward plus infinity
    function automatic longint q14_round(input longint p);
        if (p >= 0)
            return (p + 8192) >>> 14;
        return -((-p + 8191) >>> 14);
    endfunction

    // Unit ray direction for one pixel under the current camera settings
    function automatic t_dir ray_dir(input logic [11:0] px, input logic [11:0] py);
        longint sp, cp, sy, cy, w, h, s, a, b, d;
        longint f[3], r[3], u[3], v[3];
        longint unsigned m[3], big, sum, n, rem, bitv, q;
        logic neg[3];
        logic [15:0] o[3];
        int sh;
        t_dir res;
        sp = longint'($signed(cam_sp));
        cp = longint'($signed(cam_cp));
        sy = longint'($signed(cam_sy));
        cy = longint'($signed(cam_cy));
        w  = longint'(cam_w);
        h  = (cam_h == 0) ? 1 : longint'(cam_h);
        s  = longint'(cam_fov);
        f[0] = q14_round(cp * sy);
        f[1] = q14_round(cp * cy);
        f[2] = sp;
        r[0] = cy;
        r[1] = -sy;
        r[2] = 0;
        u[0] = q14_round(-sy * sp);
        u[1] = q14_round(-cy * sp);
        u[2] = cp;
        a = (2 * longint'(px) - w + 1) * s;
        b = (2 * longint'(py) - h + 1) * s;
        d = h * 16384;
        big = 0;
        for (int i = 0; i < 3; i++) begin
            v[i]   = f[i] * d + r[i] * a - u[i] * b;
            neg[i] = v[i] < 0;
            m[i]   = neg[i] ? longint'(-v[i]) : longint'(v[i]);
            if (m[i] > big)
                big = m[i];
        end
        sh = 0;
        while (sh < 63 && (big >> sh) >= (64'd1 << NORM_BITS))
            sh++;
        sum = 0;
        for (int i = 0; i < 3; i++) begin
            m[i] = m[i] >> sh;
            sum += m[i] * m[i];
        end
        // Integer square root, one bit pair at a time
        rem  = sum;
        n    = 0;
        bitv = 64'd1 << 62;
        while (bitv > rem)
            bitv >>= 2;
        while (bitv != 0) begin
            if (rem >= n + bitv) begin
                rem -= n + bitv;
                n = (n >> 1) + bitv;
            end else begin
                n >>= 1;
            end
            bitv >>= 2;
        end
        for (int i = 0; i < 3; i++) begin
            q = 0;
            if (n != 0) begin
                q = ((m[i] << 15) + (n >> 1)) / n;
                if (q > 32767)
                    q = 32767;
            end
            o[i] = neg[i] ? 16'(-q) : 16'(q);
        end
        res.x = o[0];
        res.y = o[1];
        res.z = o[2];
        return res;
    endfunction

    // Check each strobed result against the oldest expectation
    always @(posedge i_clk) begin
        t_dir e;
        if (i_rst_n && o_valid) begin
            if (pending_dirs.size() == 0) begin
                $error("unexpected result %0d %0d %0d", o_dir_x, o_dir_y, o_dir_z);
                fail_count++;
            end else begin
                e = pending_dirs.pop_front();
                if (o_dir_x !== e.x) begin
                    $error("dir_x expected %0d actual %0d", e.x, o_dir_x);
                    fail_count++;
                end
                if (o_dir_y !== e.y) begin
                    $error("dir_y expected %0d actual %0d", e.y, o_dir_y);
                    fail_count++;
                end
                if (o_dir_z !== e.z) begin
                    $error("dir_z expected %0d actual %0d", e.z, o_dir_z);
                    fail_count++;
                end
            end
        end
    end

    // Hold requests until the pipe is empty and settled
    task automatic drain();
        i_start = 1'b0;
        wait (pending_dirs.size() == 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // Write one register and mirror it
    task automatic cfg_write(input logic [CFG_IW-1:0] idx, input logic [15:0] data);
        i_cfg_we    = 1'b1;
        i_cfg_idx   = idx;
        i_cfg_wdata = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            REG_SIN_PITCH:   cam_sp  = data;
            REG_COS_PITCH:   cam_cp  = data;
            REG_SIN_YAW:     cam_sy  = data;
            REG_COS_YAW:     cam_cy  = data;
            REG_FOV_SCALE:   cam_fov = data;
            REG_VIEW_WIDTH:  cam_w   = data[12:0];
            REG_VIEW_HEIGHT: cam_h   = data[12:0];
            default: ;
        endcase
    endtask

    // Issue one request, wait for it to be taken, record its expectation
    task automatic send(input logic [11:0] px, input logic [11:0] py,
                        input logic typed, input t_dir typed_dir);
        logic ok;
        i_start   = 1'b1;
        i_pixel_x = px;
        i_pixel_y = py;
        forever begin
            ok = !o_busy;
            @(posedge i_clk);
            if (ok)
                break;
            @(negedge i_clk);
        end
        pending_dirs.push_back(typed ? typed_dir : ray_dir(px, py));
        @(negedge i_clk);
    endtask

    function automatic logic [15:0] pick_trig();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'd16384;
            3: return 16'hc000;
            4: return 16'd0;
            default: return 16'($signed($urandom_range(0, 32768)) - 16384);
        endcase
    endfunction

    function automatic logic [12:0] pick_size();
        case ($urandom_range(0, 9))
            0: return 13'd0;
            1: return 13'd1;
            2: return 13'h1fff;
            3: return 13'($urandom);
            default: return 13'($urandom_range(1, 4096));
        endcase
    endfunction

    // Directed rows: extremes, exact axes, degenerate basis, odd sizes
    t_row dir_rows[] = '{
        '{ROW_PIX, 0, 0, 0, 0, 0, '{0, 0, 0}},
        '{ROW_PIX, 0, 0, 12'hfff, 12'hfff, 0, '{0, 0, 0}},
        '{ROW_PIX, 0, 0, 0, 12'hfff, 0, '{0, 0, 0}},
        '{ROW_PIX, 0, 0, 12'hfff, 0, 0, '{0, 0, 0}},
        '{ROW_PIX, 0, 0, 320, 240, 0, '{0, 0, 0}},
        '{ROW_PIX, 0, 0, 319, 239, 0, '{0, 0, 0}},
        '{ROW_CFG, REG_FOV_SCALE, 16'd0, 0, 0, 0, '{0, 0, 0}},
        '{ROW_PIX, 0, 0, 100, 200, 1, '{0, 32767, 0}},
        '{ROW_CFG, REG_SIN_PITCH, 16'd16384, 0, 0, 0, '{0, 0, 0}},
        '{ROW_CFG, REG_COS_PITCH, 16'd0, 0, 0, 0, '{0, 0, 0}},
        '{ROW_PIX, 0, 0, 7, 9, 1, '{0, 0, 32767}},
        '{ROW_CFG, REG_SIN_PITCH, 16'd0, 0, 0, 0, '{0, 0, 0}},
        '{ROW_CFG, REG_COS_YAW, 16'd0, 0, 0, 0, '{0, 0, 0}},
        '{ROW_PIX, 0, 0, 12'hfff, 12'h0aa, 1, '{0, 0, 0}},
        '{ROW_CFG, REG_UNKNOWN, 16'hffff, 0, 0, 0, '{0, 0, 0}},
        '{ROW_PIX, 0, 0, 5, 5, 1, '{0, 0, 0}},
        '{ROW_CFG, REG_SIN_PITCH, 16'hc000, 0, 0, 0, '{0, 0, 0}},
        '{ROW_CFG, REG_COS_PITCH, 16'd16384, 0, 0, 0, '{0, 0, 0}},
        '{ROW_CFG, REG_SIN_YAW, 16'h8000, 0, 0, 0, '{0, 0, 0}},
        '{ROW_CFG, REG_COS_YAW, 16'h7fff, 0, 0, 0, '{0, 0, 0}},
        '{ROW_CFG, REG_FOV_SCALE, 16'hffff, 0, 0, 0, '{0, 0, 0}},
        '{ROW_CFG, REG_VIEW_WIDTH, 16'd0, 0, 0, 0, '{0, 0, 0}},
        '{ROW_CFG, REG_VIEW_HEIGHT, 16'd0, 0, 0, 0, '{0, 0, 0}},
        '{ROW_PIX, 0, 0, 0, 0, 0, '{0, 0, 0}},
        '{ROW_PIX, 0, 0, 12'hfff, 12'hfff, 0, '{0, 0, 0}},
        '{ROW_PIX, 0, 0, 1, 1, 0, '{0, 0, 0}}
    };

    // Stimulus
    initial begin
        int burst_left;
        logic [11:0] px, py;
        t_dir none;
        none = '{0, 0, 0};
        i_rst_n     = 1'b0;
        i_start     = 1'b0;
        i_pixel_x   = '0;
        i_pixel_y   = '0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = '0;
        i_cfg_wdata = '0;
        cam_sp  = RST_SIN_PITCH;
        cam_cp  = RST_COS_PITCH;
        cam_sy  = RST_SIN_YAW;
        cam_cy  = RST_COS_YAW;
        cam_fov = RST_FOV_SCALE;
        cam_w   = RST_VIEW_WIDTH;
        cam_h   = RST_VIEW_HEIGHT;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Walk the directed table
        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_CFG) begin
                drain();
                cfg_write(dir_rows[i].idx, dir_rows[i].data);
            end else begin
                send(dir_rows[i].px, dir_rows[i].py, dir_rows[i].typed, dir_rows[i].dir);
            end
        end

        // Random phases, each under a fresh camera setting
        for (int ph = 0; ph < 12; ph++) begin
            drain();
            if (ph == 0) begin
                // Back to the power-on camera
                cfg_write(REG_SIN_PITCH, RST_SIN_PITCH);
                cfg_write(REG_COS_PITCH, RST_COS_PITCH);
                cfg_write(REG_SIN_YAW, RST_SIN_YAW);
                cfg_write(REG_COS_YAW, RST_COS_YAW);
                cfg_write(REG_FOV_SCALE, RST_FOV_SCALE);
                cfg_write(REG_VIEW_WIDTH, 16'(RST_VIEW_WIDTH));
                cfg_write(REG_VIEW_HEIGHT, 16'(RST_VIEW_HEIGHT));
            end else begin
                cfg_write(REG_SIN_PITCH, pick_trig());
                cfg_write(REG_COS_PITCH, pick_trig());
                cfg_write(REG_SIN_YAW, pick_trig());
                cfg_write(REG_COS_YAW, pick_trig());
                cfg_write(REG_FOV_SCALE, (ph % 4 == 1) ? 16'hffff : 16'($urandom));
                cfg_write(REG_VIEW_WIDTH, {3'($urandom), pick_size()});
                cfg_write(REG_VIEW_HEIGHT, {3'($urandom), pick_size()});
                if (ph % 5 == 2)
                    cfg_write(REG_UNKNOWN, 16'($urandom));
            end
            burst_left = $urandom_range(1, 20);
            for (int k = 0; k < 95; k++) begin
                // Gap between bursts; some phases run with no gaps at all
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 20);
                    if (ph % 3 != 0) begin
                        i_start = 1'b0;
                        repeat ($urandom_range(1, 8)) @(negedge i_clk);
                    end
                end
                burst_left--;
                if ($urandom_range(0, 3) != 0 && cam_w != 0 && cam_h != 0) begin
                    px = 12'($urandom_range(0, cam_w - 1));
                    py = 12'($urandom_range(0, cam_h - 1));
                end else begin
                    px = 12'($urandom);
                    py = 12'($urandom);
                end
                send(px, py, 1'b0, none);
            end
        end

        drain();
        if (fail_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
